[design/pba_pkg.sv]
`default_nettype none

package pba_pkg;

   // Fixed page geometry.
   localparam int PAGE_BYTES    = 4096;
   localparam int PAGE_SHIFT    = $clog2(PAGE_BYTES);
   localparam int LOW_MEMORY_KB = 1024;
   localparam int KB_SHIFT      = $clog2(PAGE_BYTES / 1024);

   // Field widths fixed by the interface.
   localparam int ADDR_W   = 32;
   localparam int MEM_KB_W = 22;
   localparam int FREE_W   = 16;
   localparam int CSR_W    = 32;

   // Page numbers and page bases: a 32-bit address holds 2**20 pages, plus headroom
   // for the base of the word past the last one.
   localparam int PG_W = ADDR_W - PAGE_SHIFT + 1;

   typedef enum logic [0:0] {
      CSR_MEMORY_KB  = 1'd0,
      CSR_KERNEL_END = 1'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_INIT  = 2'd0,
      MODE_ALLOC = 2'd1,
      MODE_FREE  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_OOM      = 2'd1,
      STATUS_BAD_FREE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_SCAN,
      ST_FREE_WALK,
      ST_FREE_CHECK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [ADDR_W-1:0] release_address;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [ADDR_W-1:0] page_address;
      logic [FREE_W-1:0] pages_free;
   } rsp_type;

endpackage

`default_nettype wire

[design/pba_bitmap_ram.sv]
`default_nettype none

module pba_bitmap_ram
   import pba_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32,
   parameter int AW    = 10
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/pba_word_unit.sv]
`default_nettype none

module pba_word_unit
   import pba_pkg::*;
#(
   parameter int WORD_BITS = 32,
   parameter int BIT_W     = 5
) (
   input  wire logic [WORD_BITS-1:0] rd_data,
   input  wire logic [PG_W-1:0]      base,
   input  wire logic [PG_W-1:0]      lo,
   input  wire logic [PG_W-1:0]      hi,
   input  wire logic [BIT_W-1:0]     bit_sel,
   output logic      [WORD_BITS-1:0] init_word,
   output logic      [WORD_BITS-1:0] set_word,
   output logic      [WORD_BITS-1:0] clr_word,
   output logic                      found,
   output logic      [BIT_W-1:0]     found_bit,
   output logic                      sel_used
);

   logic [WORD_BITS-1:0] free_lane;
   logic [PG_W-1:0]      lane_page;

   // Each lane compares its own page number against the live range.
   always_comb begin
      lane_page = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         lane_page    = base + PG_W'(i);
         init_word[i] = !((lane_page >= lo) && (lane_page < hi));
         free_lane[i] = !rd_data[i] && (lane_page < hi);
      end
   end

   always_comb begin
      found     = 1'b0;
      found_bit = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (free_lane[i]) begin
            found     = 1'b1;
            found_bit = BIT_W'(i);
         end
      end
   end

   assign set_word = rd_data | (WORD_BITS'(1) << found_bit);
   assign clr_word = rd_data & ~(WORD_BITS'(1) << bit_sel);
   assign sel_used = rd_data[bit_sel];

endmodule

`default_nettype wire

[design/page_bitmap_allocator.sv]
// Init walks the whole bitmap, writing one bitmap word per cycle. Allocate reads
// one word per cycle until a free page is seen. Free reads the word that holds the
// page, checks its bit and clears it; an out-of-range page is answered without a read.
// One item at a time; the next beat is taken only once the response is loaded, and
// loading the response waits out any output stall.
// Reset: synchronous; a clearing pass over every word marks every page used first.
`default_nettype none

module page_bitmap_allocator
   import pba_pkg::*;
#(
   parameter int MAX_PAGE_COUNT = 32768,
   parameter int WORD_BITS      = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,

   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire req_type             req_payload,

   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output rsp_type                  rsp_payload,

   input  wire logic                csr_wr_en,
   input  wire csr_index_type       csr_index,
   input  wire logic [CSR_W-1:0]    csr_wdata
);

   // Bitmap geometry. The last word may carry lanes past the page capacity; those
   // lanes sit above every possible page total and are never handed out. WORD_BITS is
   // a power of two, so a page's word is its page number with the lane bits dropped.
   localparam int WORD_COUNT = (MAX_PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
   localparam int WADDR_W    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int PAGE_W     = $clog2(MAX_PAGE_COUNT + 1);

   localparam logic [PG_W-1:0]    MAX_PAGES_PG = PG_W'(MAX_PAGE_COUNT);
   localparam logic [PG_W-1:0]    WORD_STEP    = PG_W'(WORD_BITS);
   localparam logic [WADDR_W-1:0] LAST_WORD    = WADDR_W'(WORD_COUNT - 1);

   // Sequencer state and the word walk. word_ff and base_ff follow the word whose
   // data is being examined; iss_ff and iss_base_ff run one word ahead during the
   // allocate scan so that one read is issued every cycle.
   state_type           state_ff, state_in;
   logic [WADDR_W-1:0]  word_ff, word_in;
   logic [PG_W-1:0]     base_ff, base_in;
   logic [WADDR_W-1:0]  iss_ff, iss_in;
   logic [PG_W-1:0]     iss_base_ff, iss_base_in;
   logic                rdv_ff, rdv_in;
   logic                reply_ff, reply_in;

   // Allocator bookkeeping.
   logic [PAGE_W-1:0]   page_total_ff, page_total_in;
   logic [PAGE_W-1:0]   in_use_ff, in_use_in;
   logic [PG_W-1:0]     page_ff, page_in;

   // Configuration.
   logic [MEM_KB_W-1:0] mem_kb_ff, mem_kb_in;
   logic [ADDR_W-1:0]   kernel_top_ff, kernel_top_in;

   // Result being built and the output register.
   logic [1:0]          status_ff, status_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   // Memory and word unit hookup.
   logic                 wr_en;
   logic [WADDR_W-1:0]   wr_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic                 rd_en;
   logic [WADDR_W-1:0]   rd_addr;
   logic [WORD_BITS-1:0] rd_data;
   logic [WORD_BITS-1:0] init_word;
   logic [WORD_BITS-1:0] set_word;
   logic [WORD_BITS-1:0] clr_word;
   logic                 found;
   logic [BIT_W-1:0]     found_bit;
   logic                 sel_used;
   logic [BIT_W-1:0]     bit_sel;

   // Init arithmetic. The kilobyte total converts to pages by a shift, and the
   // kernel end rounds up to the next page boundary without wrapping.
   logic [MEM_KB_W:0]   kb_sum;
   logic [PG_W-1:0]     total_raw;
   logic [PG_W-1:0]     total_pg;
   logic [PG_W-1:0]     first_raw;
   logic [PG_W-1:0]     first_pg;
   logic [PG_W-1:0]     total_cur;
   logic [PG_W-1:0]     in_use_cur;
   logic [PAGE_W-1:0]   pages_free;
   logic [PG_W-1:0]     req_page;

   assign kb_sum    = {1'b0, mem_kb_ff} + (MEM_KB_W + 1)'(LOW_MEMORY_KB);
   assign total_raw = PG_W'(kb_sum >> KB_SHIFT);
   assign total_pg  = (total_raw > MAX_PAGES_PG) ? MAX_PAGES_PG : total_raw;
   assign first_raw = PG_W'(kernel_top_ff[ADDR_W-1:PAGE_SHIFT])
                      + PG_W'(kernel_top_ff[PAGE_SHIFT-1:0] != '0);
   assign first_pg  = (first_raw > MAX_PAGES_PG) ? MAX_PAGES_PG : first_raw;

   assign total_cur  = PG_W'(page_total_ff);
   assign in_use_cur = PG_W'(in_use_ff);
   assign pages_free = (page_total_ff > in_use_ff) ? (page_total_ff - in_use_ff) : '0;

   // Page number named by a free request; the offset within the page is dropped.
   assign req_page = PG_W'(req_payload.release_address[ADDR_W-1:PAGE_SHIFT]);

   // During the init sweep the pages in use still equal the first free page, so
   // that count doubles as the low edge of the range to clear. After reset both
   // bounds are zero and the sweep marks every page used.
   assign bit_sel = BIT_W'(page_ff - base_ff);

   pba_bitmap_ram #(
      .DEPTH (WORD_COUNT),
      .WIDTH (WORD_BITS),
      .AW    (WADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pba_word_unit #(
      .WORD_BITS (WORD_BITS),
      .BIT_W     (BIT_W)
   ) u_word (
      .rd_data   (rd_data),
      .base      (base_ff),
      .lo        (in_use_cur),
      .hi        (total_cur),
      .bit_sel   (bit_sel),
      .init_word (init_word),
      .set_word  (set_word),
      .clr_word  (clr_word),
      .found     (found),
      .found_bit (found_bit),
      .sel_used  (sel_used)
   );

   // CSR writes land directly; the user must write only while idle; nothing enforces it.
   always_comb begin
      mem_kb_in     = mem_kb_ff;
      kernel_top_in = kernel_top_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_MEMORY_KB: begin
               mem_kb_in = csr_wdata[MEM_KB_W-1:0];
            end
            CSR_KERNEL_END: begin
               kernel_top_in = csr_wdata[ADDR_W-1:0];
            end
            default: begin
               mem_kb_in = mem_kb_ff;
            end
         endcase
      end
   end

   // Sequencer: next state, counters, memory strobes and result.
   always_comb begin
      state_in      = state_ff;
      word_in       = word_ff;
      base_in       = base_ff;
      iss_in        = iss_ff;
      iss_base_in   = iss_base_ff;
      rdv_in        = 1'b0;
      reply_in      = reply_ff;
      page_total_in = page_total_ff;
      in_use_in     = in_use_ff;
      page_in       = page_ff;
      status_in     = status_ff;
      addr_in       = addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = word_ff;
      wr_data       = init_word;
      rd_en         = 1'b0;
      rd_addr       = word_ff;
      req_ready     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               word_in     = '0;
               base_in     = '0;
               iss_in      = '0;
               iss_base_in = '0;
               status_in   = STATUS_OK;
               addr_in     = '0;
               page_in     = req_page;
               case (req_payload.mode)
                  MODE_INIT: begin
                     page_total_in = PAGE_W'(total_pg);
                     in_use_in     = PAGE_W'(first_pg);
                     reply_in      = 1'b1;
                     state_in      = ST_INIT;
                  end
                  MODE_ALLOC: begin
                     state_in = ST_SCAN;
                  end
                  MODE_FREE: begin
                     // Go straight to the word that holds the page. An out-of-range
                     // page is rejected before its word index is used.
                     word_in  = WADDR_W'(req_page[PG_W-1:BIT_W]);
                     base_in  = {req_page[PG_W-1:BIT_W], {BIT_W{1'b0}}};
                     state_in = ST_FREE_WALK;
                  end
                  default: begin
                     // The unused mode does nothing and reports success.
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_INIT: begin
            wr_en   = 1'b1;
            wr_addr = word_ff;
            wr_data = init_word;
            word_in = word_ff + WADDR_W'(1);
            base_in = base_ff + WORD_STEP;
            if (word_ff == LAST_WORD) begin
               state_in = reply_ff ? ST_DONE : ST_IDLE;
               reply_in = 1'b0;
            end
         end

         ST_SCAN: begin
            if (rdv_ff && found) begin
               wr_en     = 1'b1;
               wr_addr   = word_ff;
               wr_data   = set_word;
               in_use_in = in_use_ff + PAGE_W'(1);
               addr_in   = ADDR_W'({base_ff + PG_W'(found_bit), {PAGE_SHIFT{1'b0}}});
               status_in = STATUS_OK;
               state_in  = ST_DONE;
            end else begin
               if (rdv_ff) begin
                  word_in = word_ff + WADDR_W'(1);
                  base_in = base_ff + WORD_STEP;
               end
               if (iss_base_ff < total_cur) begin
                  rd_en       = 1'b1;
                  rd_addr     = iss_ff;
                  iss_in      = iss_ff + WADDR_W'(1);
                  iss_base_in = iss_base_ff + WORD_STEP;
                  rdv_in      = 1'b1;
               end else if (!rdv_ff) begin
                  // Every word below the page total was seen without a free page.
                  status_in = STATUS_OOM;
                  addr_in   = '0;
                  state_in  = ST_DONE;
               end
            end
         end

         ST_FREE_WALK: begin
            if (page_ff >= total_cur) begin
               status_in = STATUS_BAD_FREE;
               state_in  = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = word_ff;
               state_in = ST_FREE_CHECK;
            end
         end

         ST_FREE_CHECK: begin
            if (sel_used) begin
               wr_en   = 1'b1;
               wr_addr = word_ff;
               wr_data = clr_word;
               if (in_use_ff != '0) begin
                  in_use_in = in_use_ff - PAGE_W'(1);
               end
            end else begin
               // The page is already free; leave the count alone.
               status_in = STATUS_BAD_FREE;
            end
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.status       = status_ff;
               rsp_in.page_address = addr_ff;
               rsp_in.pages_free   = FREE_W'(pages_free);
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff       <= '0;
         base_ff       <= '0;
         iss_ff        <= '0;
         iss_base_ff   <= '0;
         rdv_ff        <= 1'b0;
         reply_ff      <= 1'b0;
         page_total_ff <= '0;
         in_use_ff     <= '0;
         mem_kb_ff     <= '0;
         kernel_top_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         word_ff       <= word_in;
         base_ff       <= base_in;
         iss_ff        <= iss_in;
         iss_base_ff   <= iss_base_in;
         rdv_ff        <= rdv_in;
         reply_ff      <= reply_in;
         page_total_ff <= page_total_in;
         in_use_ff     <= in_use_in;
         mem_kb_ff     <= mem_kb_in;
         kernel_top_ff <= kernel_top_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff   <= page_in;
      status_ff <= status_in;
      addr_ff   <= addr_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

[tb/pba_frame_checker.sv]
`timescale 1ns / 100ps

module pba_frame_checker
   import pba_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,

   input  wire logic             req_valid,
   input  wire logic             req_ready,
   input  wire req_type          req_payload,

   input  wire logic             rsp_valid,
   input  wire logic             rsp_ready,
   input  wire rsp_type          rsp_payload,

   input  wire logic             csr_wr_en,
   input  wire csr_index_type    csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata,

   output int                    mismatch_count,
   output int                    outstanding
);

   localparam int PAGE_LIMIT = 32768;
   localparam int MAP_WORDS  = PAGE_LIMIT / 32;

   logic [31:0]         used_map [MAP_WORDS];
   int unsigned         live_pages;
   int unsigned         busy_pages;
   logic [MEM_KB_W-1:0] memory_kb;
   logic [ADDR_W-1:0]   kernel_top_addr;
   rsp_type             pending_frame_results [$];
   rsp_type             wanted;

   initial begin
      foreach (used_map[w]) used_map[w] = '1;
      live_pages      = 0;
      busy_pages      = 0;
      memory_kb       = '0;
      kernel_top_addr = '0;
      mismatch_count  = 0;
      outstanding     = 0;
   end

   function automatic logic page_busy(input int unsigned page);
      return used_map[page / 32][page % 32];
   endfunction

   function automatic void mark_page(input int unsigned page, input logic busy);
      used_map[page / 32][page % 32] = busy;
   endfunction

   // Applies one request beat to the mirrored bitmap and returns the response it must produce.
   function automatic rsp_type next_frame_result(input req_type beat);
      rsp_type         outcome;
      longint unsigned span;
      longint unsigned first_page;
      int unsigned     page;
      bit              found;
      outcome = '0;
      found   = 1'b0;
      case (beat.mode)
         MODE_INIT: begin
            // Four kilobytes per page, low megabyte included.
            span       = 64'(memory_kb);
            span       = (span + LOW_MEMORY_KB) / 4;
            first_page = 64'(kernel_top_addr);
            first_page = (first_page + PAGE_BYTES - 1) / PAGE_BYTES;
            if (span > PAGE_LIMIT) span = PAGE_LIMIT;
            if (first_page > PAGE_LIMIT) first_page = PAGE_LIMIT;
            live_pages = 32'(span);
            busy_pages = 32'(first_page);
            foreach (used_map[w]) used_map[w] = '1;
            for (page = 32'(first_page); page < live_pages; page++) mark_page(page, 1'b0);
         end
         MODE_ALLOC: begin
            for (page = 0; page < live_pages && !found; page++) begin
               if (!page_busy(page)) begin
                  mark_page(page, 1'b1);
                  busy_pages++;
                  outcome.page_address = page << PAGE_SHIFT;
                  found = 1'b1;
               end
            end
            if (!found) outcome.status = STATUS_OOM;
         end
         MODE_FREE: begin
            page = beat.release_address >> PAGE_SHIFT;
            if (page >= live_pages || !page_busy(page)) begin
               outcome.status = STATUS_BAD_FREE;
            end else begin
               mark_page(page, 1'b0);
               if (busy_pages > 0) busy_pages--;
            end
         end
         default: ;
      endcase
      outcome.pages_free = FREE_W'((live_pages > busy_pages) ? live_pages - busy_pages : 0);
      return outcome;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t pba_frame_checker: %s", $time, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MEMORY_KB:  memory_kb       = csr_wdata[MEM_KB_W-1:0];
               CSR_KERNEL_END: kernel_top_addr = csr_wdata[ADDR_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            pending_frame_results.push_back(next_frame_result(req_payload));
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_frame_results.size() == 0) begin
               report_mismatch($sformatf("response beat with nothing pending: %0d 0x%08h %0d",
                  rsp_payload.status, rsp_payload.page_address, rsp_payload.pages_free));
            end else begin
               wanted = pending_frame_results.pop_front();
               if (rsp_payload.status !== wanted.status) begin
                  report_mismatch($sformatf("status %0d, expected %0d",
                     rsp_payload.status, wanted.status));
               end
               if (rsp_payload.page_address !== wanted.page_address) begin
                  report_mismatch($sformatf("page_address 0x%08h, expected 0x%08h",
                     rsp_payload.page_address, wanted.page_address));
               end
               if (rsp_payload.pages_free !== wanted.pages_free) begin
                  report_mismatch($sformatf("pages_free %0d, expected %0d",
                     rsp_payload.pages_free, wanted.pages_free));
               end
            end
         end
         outstanding = pending_frame_results.size();
      end
   end

endmodule

[tb/page_bitmap_allocator_test.sv]
`timescale 1ns / 100ps

module page_bitmap_allocator_test;
   import pba_pkg::*;

   // Mode 3 has no meaning; the block must answer it with a plain success beat.
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // The receiver hold-off is longer than the slowest item, so the block fills and
   // drops req_ready while the sender keeps offering.
   localparam int LONG_HOLD_CYCLES = 3000;
   // Slack after the last response: a bit more than one full bitmap walk.
   localparam int TAIL_CYCLES      = 1100;
   localparam int PHASE_ITEMS      = 70;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   req_type           req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   rsp_type           rsp_payload;
   logic              csr_wr_en   = 1'b0;
   csr_index_type     csr_index   = CSR_MEMORY_KB;
   logic [CSR_W-1:0]  csr_wdata   = '0;

   int                mismatch_count;
   int                outstanding;

   // Idling knobs, changed only while nothing is in flight.
   int                send_idle_pct     = 0;
   int                recv_stall_pct    = 0;
   bit                long_hold_pending = 1'b0;

   // What the next init will build from the registers last written. The stimulus uses
   // this only to aim frees at pages that are likely to be in use.
   int unsigned       next_total        = 256;
   int unsigned       next_first        = 0;
   int unsigned       allocs_since_init = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   page_bitmap_allocator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   pba_frame_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   // Offers one request beat. It is entered and left at a falling edge. Valid is left
   // high on return so that back-to-back beats keep it high; whoever pauses the
   // request side lowers it.
   task automatic send_beat(input logic [1:0] mode, input logic [ADDR_W-1:0] addr);
      req_type beat;
      beat.mode            = mode;
      beat.release_address = addr;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Stops offering and waits until every response beat has come back.
   task automatic settle();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // Every item answers with exactly one beat, so once nothing is outstanding the
   // block is idle and both registers can be rewritten.
   task automatic apply_config(input logic [CSR_W-1:0] mem_word,
                               input logic [CSR_W-1:0] kend_word);
      longint unsigned span;
      longint unsigned first_page;
      settle();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_MEMORY_KB;
      csr_wdata <= mem_word;
      @(negedge clock);
      csr_index <= CSR_KERNEL_END;
      csr_wdata <= kend_word;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      span       = 64'(mem_word[MEM_KB_W-1:0]);
      span       = (span + LOW_MEMORY_KB) / 4;
      first_page = 64'(kend_word);
      first_page = (first_page + PAGE_BYTES - 1) / PAGE_BYTES;
      next_total = 32'((span > 32768) ? 32768 : span);
      next_first = 32'((first_page > 32768) ? 32768 : first_page);
   endtask

   // One random item. Most frees are aimed at pages that are probably in use: the
   // pages handed out since the last init sit just above the kernel end, and the
   // kernel pages themselves are marked used by every init. The rest are stray frees.
   task automatic random_item();
      int unsigned roll;
      int unsigned page;
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         allocs_since_init = 0;
         send_beat(MODE_INIT, $urandom);
      end else if (roll < 7) begin
         send_beat(MODE_UNUSED, $urandom);
      end else if (roll < 52) begin
         allocs_since_init++;
         send_beat(MODE_ALLOC, $urandom);
      end else if (roll < 82) begin
         if (next_first > 0 && $urandom_range(0, 4) == 0) begin
            page = $urandom_range(0, next_first - 1);
         end else begin
            page = next_first + $urandom_range(0, allocs_since_init + 1);
         end
         send_beat(MODE_FREE, {page[19:0], 12'($urandom)});
      end else if (roll < 92) begin
         page = $urandom_range(0, next_total + 8);
         send_beat(MODE_FREE, {page[19:0], 12'($urandom)});
      end else begin
         send_beat(MODE_FREE, $urandom);
      end
   endtask

   // A random phase always opens with an init so the new registers take effect.
   task automatic run_phase(input logic [CSR_W-1:0] mem_word, input logic [CSR_W-1:0] kend_word,
                            input int idle, input int stall, input int count, input bit hold);
      apply_config(mem_word, kend_word);
      send_idle_pct     = idle;
      recv_stall_pct    = stall;
      long_hold_pending = hold;
      allocs_since_init = 0;
      send_beat(MODE_INIT, $urandom);
      repeat (count - 1) random_item();
   endtask

   // Response side. A requested long hold-off is counted here, beat by beat of the
   // clock, while the stimulus process keeps pushing requests.
   initial begin : rsp_side
      int hold_left;
      forever begin
         @(negedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_ready <= 1'b0;
            for (hold_left = LONG_HOLD_CYCLES; hold_left > 0; hold_left--) @(negedge clock);
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   initial begin : stimulus
      int               phase;
      int               idle;
      int               stall;
      int unsigned      mem_kb;
      int unsigned      total;
      int unsigned      first;
      logic [CSR_W-1:0] mem_word;
      logic [CSR_W-1:0] kend_word;

      // Synchronous reset; the block then runs its own clearing pass and holds
      // req_ready low until that is done, which send_beat simply waits out.
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Straight out of reset the page total is zero: allocate runs out of memory
      // and any free is out of range. Then a default init gives 256 free pages.
      send_beat(MODE_ALLOC, 32'h0);
      send_beat(MODE_FREE, 32'h0);
      send_beat(MODE_UNUSED, 32'hFFFF_FFFF);
      send_beat(MODE_INIT, 32'h0);
      send_beat(MODE_ALLOC, 32'h0);
      send_beat(MODE_ALLOC, 32'h0);
      // Offset bits within the page are ignored; the second free of the same page
      // is a double free, and the two after it are out of range.
      send_beat(MODE_FREE, 32'h0000_1FFF);
      send_beat(MODE_FREE, 32'h0000_1234);
      send_beat(MODE_FREE, 32'h0010_0000);
      send_beat(MODE_FREE, 32'hFFFF_FFFF);
      send_beat(MODE_ALLOC, 32'h0);

      // Largest memory, clamped to the page capacity, with an unaligned kernel end
      // that rounds up to page two. Freeing a kernel page is legal and lets the
      // next allocate take page zero.
      apply_config(32'h003F_FFFF, 32'h0000_1001);
      send_beat(MODE_INIT, 32'h0);
      send_beat(MODE_ALLOC, 32'h0);
      send_beat(MODE_FREE, 32'h07FF_F000);
      send_beat(MODE_FREE, 32'h0000_0ABC);
      send_beat(MODE_ALLOC, 32'h0);

      // Kernel end at the top of the address space: the first free page would lie
      // far above the total, nothing is freed and the free count reads zero.
      apply_config(32'h0, 32'hFFFF_FFFF);
      send_beat(MODE_INIT, 32'h0);
      send_beat(MODE_ALLOC, 32'h0);
      send_beat(MODE_FREE, 32'h0000_5000);
      send_beat(MODE_ALLOC, 32'h0);

      // Kernel end lands exactly on the page total: one freed page, one allocate
      // that takes it, then out of memory.
      apply_config(32'd1027, 32'h001F_F001);
      send_beat(MODE_INIT, 32'h0);
      send_beat(MODE_FREE, 32'h001F_F000);
      send_beat(MODE_ALLOC, 32'h0);
      send_beat(MODE_ALLOC, 32'h0);

      // Random phases cycle through the idling patterns. Most use small memories so
      // the bitmap walks stay short; one uses the full capacity and one the
      // smallest. Each of the others puts the kernel end close to the page total with
      // even odds, so that allocates run dry. Outside the smallest phase the unused high
      // bits of the memory register get random values.
      for (phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0:       begin idle = 0;  stall = 0;  end
            1:       begin idle = 87; stall = 0;  end
            2:       begin idle = 0;  stall = 87; end
            default: begin idle = 29; stall = 29; end
         endcase
         if (phase == 3) begin
            mem_word  = {10'($urandom), 22'h3F_FFFF};
            kend_word = '0;
         end else if (phase == 6) begin
            mem_word  = '0;
            kend_word = $urandom_range(0, 4095);
         end else begin
            mem_kb = $urandom_range(0, 2047);
            total  = (mem_kb + LOW_MEMORY_KB) / 4;
            if ($urandom_range(0, 1) == 1) begin
               first = $urandom_range(0, total);
            end else begin
               first = total - $urandom_range(0, 24);
            end
            kend_word = (first == 0) ? '0 : first * PAGE_BYTES - $urandom_range(0, 4095);
            mem_word  = {10'($urandom), 22'(mem_kb)};
         end
         run_phase(mem_word, kend_word, idle, stall, PHASE_ITEMS, phase == 0);
      end

      settle();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("page_bitmap_allocator_test: PASS");
      end else begin
         $display("page_bitmap_allocator_test: FAIL");
      end
      $finish;
   end

   // Guard against a hang: several times the slowest legal run.
   initial begin : watchdog
      #10_000_000;
      $display("page_bitmap_allocator_test: FAIL");
      $finish;
   end

endmodule
